// ===== hdl/hcy_pkg.sv =====
// Shared types, constants and helpers for the HCY to RGB converter.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package hcy_pkg;

  localparam int CompBits   = 8;
  localparam int FracBits   = 16;
  localparam int WeightBits = 16;
  localparam int FracW      = FracBits + 1;   // holds 0 .. 1.0 inclusive
  localparam int ProdW      = 2 * FracW;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = 2;
  localparam int DivSteps   = FracW;

  localparam logic [FracW-1:0]    One      = FracW'(1) << FracBits;
  localparam logic [CompBits-1:0] CodeMax  = '1;

  // config register indexes
  localparam logic [1:0] RegRedWeight   = 2'd0;
  localparam logic [1:0] RegGreenWeight = 2'd1;
  localparam logic [1:0] RegBlueWeight  = 2'd2;

  localparam logic [WeightBits-1:0] RedWeightRst   = 16'd19595;
  localparam logic [WeightBits-1:0] GreenWeightRst = 16'd38470;
  localparam logic [WeightBits-1:0] BlueWeightRst  = 16'd7471;

  // hue sextants
  localparam logic [2:0] SecRedYel  = 3'd0;
  localparam logic [2:0] SecYelGrn  = 3'd1;
  localparam logic [2:0] SecGrnCyan = 3'd2;
  localparam logic [2:0] SecCyanBlu = 3'd3;
  localparam logic [2:0] SecBluMag  = 3'd4;
  localparam logic [2:0] SecMagRed  = 3'd5;

  typedef logic [FracW-1:0]      frac_t;
  typedef logic [CompBits-1:0]   code_t;
  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [2:0]            sext_t;

  typedef struct packed {
    weight_t wr;
    weight_t wg;
    weight_t wb;
  } weights_t;

  // one classified item passed from front to back
  typedef struct packed {
    sext_t sec;
    frac_t xf;
    frac_t c;
    frac_t y;
    frac_t peak;
  } item_t;

  // fields that ride alongside the divider
  typedef struct packed {
    sext_t sec;
    frac_t xf;
    frac_t y;
  } side_t;

  // code * 2^16 / 255 = code * 257 + (code == 255)
  function automatic frac_t code_frac(input code_t v);
    frac_t base;
    base = {1'b0, v, v};
    return base + frac_t'(v == CodeMax);
  endfunction

  function automatic frac_t weight_frac(input weight_t w);
    return {1'b0, w};
  endfunction

endpackage

// ===== hdl/hcy_front.sv =====
// Front end: takes items, finds sextant, fraction, scaled chroma and luma, peak luma.
// Two register stages; depends on hcy_pkg.
`timescale 1ns / 1ps

module hcy_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  hcy_pkg::code_t          in_hue,
  input  hcy_pkg::code_t          in_chroma,
  input  hcy_pkg::code_t          in_luma,
  input  hcy_pkg::weights_t       weights,
  output logic                    push,
  output hcy_pkg::item_t          push_item,
  input  logic                    q_full
);

  logic                   en;
  hcy_pkg::code_t         hue;
  logic [10:0]            hue6;
  logic [2:0]             hq;
  logic [18:0]            h6;
  hcy_pkg::sext_t         sec;
  logic [15:0]            f;
  hcy_pkg::frac_t         wr, wg, wb, a, b;

  logic                   v1_r, v2_r;
  hcy_pkg::sext_t         sec1_r;
  logic [15:0]            f1_r;
  hcy_pkg::frac_t         xf1_r, c1_r, y1_r, a1_r, b1_r;
  hcy_pkg::item_t         item2_r;

  logic [hcy_pkg::ProdW-1:0] pa, pb;
  logic [hcy_pkg::ProdW:0]   psum;
  hcy_pkg::frac_t            om_f;

  assign en       = !(v2_r && q_full);
  assign in_stall = !en;

  // hue * 6 / 255 exactly: 6 * hue * 257 plus the whole part of 6 * hue / 255
  assign hue  = (in_hue == hcy_pkg::CodeMax) ? '0 : in_hue;
  assign hue6 = 11'(hue) * 11'd6;
  assign hq   = 3'(hue6 >= 11'd255) + 3'(hue6 >= 11'd510) + 3'(hue6 >= 11'd765)
              + 3'(hue6 >= 11'd1020) + 3'(hue6 >= 11'd1275);
  assign h6   = 19'(hue) * 19'd1542 + 19'(hq);
  assign sec  = h6[18:16];
  assign f    = h6[15:0];

  assign wr = hcy_pkg::weight_frac(weights.wr);
  assign wg = hcy_pkg::weight_frac(weights.wg);
  assign wb = hcy_pkg::weight_frac(weights.wb);

  always_comb begin
    unique case (sec)
      hcy_pkg::SecRedYel:  begin a = wr;                b = hcy_pkg::One - wb; end
      hcy_pkg::SecYelGrn:  begin a = hcy_pkg::One - wb; b = wg;                end
      hcy_pkg::SecGrnCyan: begin a = wg;                b = hcy_pkg::One - wr; end
      hcy_pkg::SecCyanBlu: begin a = hcy_pkg::One - wr; b = wb;                end
      hcy_pkg::SecBluMag:  begin a = wb;                b = hcy_pkg::One - wg; end
      default:             begin a = hcy_pkg::One - wg; b = wr;                end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  // peak luma: linear blend of the sextant's corner lumas
  assign om_f = hcy_pkg::One - {1'b0, f1_r};
  assign pa   = a1_r * om_f;
  assign pb   = b1_r * {1'b0, f1_r};
  assign psum = {1'b0, pa} + {1'b0, pb};

  always_ff @(posedge clk) begin
    if (en) begin
      sec1_r <= sec;
      f1_r   <= f;
      xf1_r  <= sec[0] ? hcy_pkg::One - {1'b0, f} : {1'b0, f};
      c1_r   <= hcy_pkg::code_frac(in_chroma);
      y1_r   <= hcy_pkg::code_frac(in_luma);
      a1_r   <= a;
      b1_r   <= b;
      item2_r.sec  <= sec1_r;
      item2_r.xf   <= xf1_r;
      item2_r.c    <= c1_r;
      item2_r.y    <= y1_r;
      item2_r.peak <= psum[hcy_pkg::FracBits + hcy_pkg::FracW - 1:hcy_pkg::FracBits];
    end
  end

  assign push      = v2_r && !q_full;
  assign push_item = item2_r;

endmodule

// ===== hdl/hcy_queue.sv =====
// Small register queue between front and back.
// Depends on hcy_pkg for the item type and depth.
`timescale 1ns / 1ps

module hcy_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hcy_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output hcy_pkg::item_t  pop_item
);

  hcy_pkg::item_t                mem_r [hcy_pkg::QueueDepth];
  logic [hcy_pkg::QueueAw-1:0]   wp_r, rp_r;
  logic [hcy_pkg::QueueAw:0]     cnt_r;

  assign full     = (cnt_r == (hcy_pkg::QueueAw + 1)'(hcy_pkg::QueueDepth));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

// ===== hdl/hcy_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband fields.
// Depends on hcy_pkg.
`timescale 1ns / 1ps

module hcy_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [hcy_pkg::ProdW-1:0]      dividend,
  input  hcy_pkg::frac_t                 divisor,
  input  hcy_pkg::side_t                 in_side,
  output logic                           out_valid,
  output hcy_pkg::frac_t                 quotient,
  output hcy_pkg::side_t                 out_side
);

  localparam int N  = hcy_pkg::DivSteps;
  localparam int FW = hcy_pkg::FracW;

  logic            v_r    [N];
  logic [FW-1:0]   rem_r  [N];
  logic [FW-1:0]   low_r  [N];
  logic [FW-1:0]   q_r    [N];
  logic [FW-1:0]   den_r  [N];
  hcy_pkg::side_t  side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           pv;
    logic [FW-1:0]  prem, plow, pq, pden;
    hcy_pkg::side_t pside;
    logic [FW:0]    trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      // quotient stays below 2^17, so the top half is already below the divisor
      assign pv    = in_valid;
      assign prem  = dividend[hcy_pkg::ProdW-1:FW];
      assign plow  = dividend[FW-1:0];
      assign pq    = '0;
      assign pden  = divisor;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign plow  = low_r[k-1];
      assign pq    = q_r[k-1];
      assign pden  = den_r[k-1];
      assign pside = side_r[k-1];
    end

    assign trial = {prem, plow[FW-1]};
    assign diff  = trial - {1'b0, pden};
    assign ge    = trial >= {1'b0, pden};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[FW-1:0] : trial[FW-1:0];
        low_r[k]  <= {plow[FW-2:0], 1'b0};
        q_r[k]    <= {pq[FW-2:0], ge};
        den_r[k]  <= pden;
        side_r[k] <= pside;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign quotient  = q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// ===== hdl/hcy_back.sv =====
// Back end: chroma scaling by division, second component, placement, luma offset, output.
// Depends on hcy_pkg and hcy_div.
`timescale 1ns / 1ps

module hcy_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hcy_pkg::item_t     q_item,
  output logic               pop,
  input  hcy_pkg::weights_t  weights,
  output logic               out_valid,
  input  logic               out_stall,
  output hcy_pkg::code_t     out_red,
  output hcy_pkg::code_t     out_green,
  output hcy_pkg::code_t     out_blue
);

  localparam int FW = hcy_pkg::FracW;
  localparam int FB = hcy_pkg::FracBits;

  logic                       en;
  logic                       lt;
  hcy_pkg::frac_t             num, den;

  logic                       v1_r;
  logic [hcy_pkg::ProdW-1:0]  prod1_r;
  hcy_pkg::frac_t             den1_r;
  hcy_pkg::side_t             side1_r;

  logic                       dv;
  hcy_pkg::frac_t             dq;
  hcy_pkg::side_t             dside;
  logic [hcy_pkg::ProdW-1:0]  xprod;

  logic                       v3_r;
  hcy_pkg::frac_t             c3_r, x3_r, y3_r;
  hcy_pkg::sext_t             sec3_r;

  hcy_pkg::frac_t             r, g, bl;
  logic [FW+15:0]             pr, pg, pb;
  logic [FW+17:0]             wsum;

  logic                       v4_r;
  hcy_pkg::frac_t             r4_r, g4_r, b4_r, y4_r;
  logic [FW+1:0]              sum4_r;
  logic signed [FW+3:0]       m;

  logic                       out_valid_r;
  hcy_pkg::code_t             red_r, green_r, blue_r;

  function automatic hcy_pkg::code_t to_code(input logic signed [FW+4:0] v);
    logic [FW+12:0] s;
    logic [FW-4:0]  q;
    s = FW'(0) + ((FW + 13)'(unsigned'(v)) << 8) - (FW + 13)'(unsigned'(v));
    q = s[FW+12:16];
    if (v <= 0) return '0;
    if (q > (FW - 3)'(hcy_pkg::CodeMax)) return hcy_pkg::CodeMax;
    return q[hcy_pkg::CompBits-1:0];
  endfunction

  assign en  = !out_valid_r || !out_stall;
  assign pop = en && !q_empty;

  // below the peak scale by y/peak, at or above it by (1-y)/(1-peak)
  assign lt  = q_item.y < q_item.peak;
  assign num = lt ? q_item.y : hcy_pkg::One - q_item.y;
  assign den = lt ? q_item.peak : hcy_pkg::One - q_item.peak;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= !q_empty;
      v3_r        <= dv;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r     <= q_item.c * num;
      den1_r      <= den;
      side1_r.sec <= q_item.sec;
      side1_r.xf  <= q_item.xf;
      side1_r.y   <= q_item.y;
    end
  end

  hcy_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .dividend  (prod1_r),
    .divisor   (den1_r),
    .in_side   (side1_r),
    .out_valid (dv),
    .quotient  (dq),
    .out_side  (dside)
  );

  assign xprod = dq * dside.xf;

  always_ff @(posedge clk) begin
    if (en) begin
      c3_r   <= dq;
      x3_r   <= xprod[FB+FW-1:FB];
      y3_r   <= dside.y;
      sec3_r <= dside.sec;
    end
  end

  always_comb begin
    r  = '0;
    g  = '0;
    bl = '0;
    unique case (sec3_r)
      hcy_pkg::SecRedYel:  begin r = c3_r;  g  = x3_r; end
      hcy_pkg::SecYelGrn:  begin r = x3_r;  g  = c3_r; end
      hcy_pkg::SecGrnCyan: begin g = c3_r;  bl = x3_r; end
      hcy_pkg::SecCyanBlu: begin g = x3_r;  bl = c3_r; end
      hcy_pkg::SecBluMag:  begin r = x3_r;  bl = c3_r; end
      default:             begin r = c3_r;  bl = x3_r; end
    endcase
  end

  assign pr   = weights.wr * r;
  assign pg   = weights.wg * g;
  assign pb   = weights.wb * bl;
  assign wsum = (FW + 18)'(pr) + (FW + 18)'(pg) + (FW + 18)'(pb);

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r   <= r;
      g4_r   <= g;
      b4_r   <= bl;
      y4_r   <= y3_r;
      sum4_r <= wsum[FW+17:FB];
    end
  end

  assign m = $signed({3'b000, y4_r}) - $signed({2'b00, sum4_r});

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= to_code($signed({4'b0000, r4_r}) + (FW + 5)'(m));
      green_r <= to_code($signed({4'b0000, g4_r}) + (FW + 5)'(m));
      blue_r  <= to_code($signed({4'b0000, b4_r}) + (FW + 5)'(m));
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule

// ===== hdl/hcy_to_rgb_converter_top.sv =====
// HCY to RGB converter: one item in and one result out per clock when not stalled.
// Stages from accept to result: 2 front stages, the queue,
// 1 multiply stage, 17 divider stages (one quotient bit each), 3 more back stages.
// Synchronous active-low reset clears all valid state and loads the default luma weights.
// Depends on hcy_pkg, hcy_front, hcy_queue, hcy_back.
`timescale 1ns / 1ps

module hcy_to_rgb_converter_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  hcy_pkg::code_t        in_hue,
  input  hcy_pkg::code_t        in_chroma,
  input  hcy_pkg::code_t        in_luma,
  output logic                  out_valid,
  input  logic                  out_stall,
  output hcy_pkg::code_t        out_red,
  output hcy_pkg::code_t        out_green,
  output hcy_pkg::code_t        out_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  hcy_pkg::weight_t      cfg_data
);

  hcy_pkg::weights_t weights_r;
  logic              push, q_full, pop, q_empty;
  hcy_pkg::item_t    push_item, pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_r.wr <= hcy_pkg::RedWeightRst;
      weights_r.wg <= hcy_pkg::GreenWeightRst;
      weights_r.wb <= hcy_pkg::BlueWeightRst;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == hcy_pkg::RegRedWeight)   weights_r.wr <= cfg_data;
      if (cfg_index == hcy_pkg::RegGreenWeight) weights_r.wg <= cfg_data;
      if (cfg_index == hcy_pkg::RegBlueWeight)  weights_r.wb <= cfg_data;
    end
  end

  hcy_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_hue    (in_hue),
    .in_chroma (in_chroma),
    .in_luma   (in_luma),
    .weights   (weights_r),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  hcy_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (pop_item)
  );

  hcy_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .weights   (weights_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// ===== hdl/hcy_checker.sv =====
// Port-level checks for the converter top level, attached by bind.
// Depends on hcy_pkg.
`timescale 1ns / 1ps

module hcy_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input hcy_pkg::code_t out_red,
  input hcy_pkg::code_t out_green,
  input hcy_pkg::code_t out_blue
);

  // items held inside: 2 front stages, queue, 21 back stages
  localparam logic [5:0] MaxHeld = 6'd27;

  logic [5:0] held_r;
  logic       acc_in, acc_out;

  assign acc_in  = in_valid && !in_stall;
  assign acc_out = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (acc_in && !acc_out) begin
      held_r <= held_r + 1'b1;
    end else if (acc_out && !acc_in) begin
      held_r <= held_r - 1'b1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
                               && $stable(out_blue))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> held_r != '0)
    else $error("result with no item inside");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= MaxHeld)
    else $error("more items inside than the pipeline holds");

endmodule

bind hcy_to_rgb_converter_top hcy_checker u_hcy_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the HCY to RGB converter: it drives pixels and luma weights and
// compares every RGB result with a behavioural predictor of the converter's fixed point maths.
// Depends on hcy_pkg and hcy_to_rgb_converter_top.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] RegUnused = 2'd3;   // no register at this index
  localparam int         WdLimit   = 20000;
  localparam int         Drain     = 40;

  typedef struct {
    hcy_pkg::code_t r;
    hcy_pkg::code_t g;
    hcy_pkg::code_t b;
  } rgb_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  hcy_pkg::code_t   in_hue = '0, in_chroma = '0, in_luma = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  hcy_pkg::code_t   out_red, out_green, out_blue;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  hcy_pkg::weight_t cfg_data = '0;

  hcy_pkg::weight_t wt_red   = hcy_pkg::RedWeightRst;
  hcy_pkg::weight_t wt_green = hcy_pkg::GreenWeightRst;
  hcy_pkg::weight_t wt_blue  = hcy_pkg::BlueWeightRst;
  rgb_t    pending_rgb[$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      hold_cycles = 0;
  int      stall_left = 0;
  bit      in_gaps = 1'b1;
  bit      out_gaps = 1'b1;

  hcy_to_rgb_converter_top u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] frac_of(input hcy_pkg::code_t v);
    return (64'(v) << hcy_pkg::FracBits) / 64'(hcy_pkg::CodeMax);
  endfunction

  function automatic hcy_pkg::code_t code_of(input longint v);
    logic [63:0] q;
    if (v <= 0) return '0;
    q = (64'(v) * 64'(hcy_pkg::CodeMax)) >> hcy_pkg::FracBits;
    return (q > 64'(hcy_pkg::CodeMax)) ? hcy_pkg::CodeMax : hcy_pkg::code_t'(q);
  endfunction

  function automatic rgb_t hcy_to_rgb(input hcy_pkg::code_t hue, input hcy_pkg::code_t chroma,
                                      input hcy_pkg::code_t luma);
    logic [63:0] one, c, y, wr, wg, wb, h6, sec, f, xf, a, b, peak, x, r, g, bl, sum;
    longint m;
    rgb_t o;
    one = 64'd1 << hcy_pkg::FracBits;
    c = frac_of(chroma);
    y = frac_of(luma);
    wr = 64'(wt_red);
    wg = 64'(wt_green);
    wb = 64'(wt_blue);
    if (hue == hcy_pkg::CodeMax) hue = '0;   // a full turn wraps to zero
    h6 = (64'(hue) * 6 * one) / 64'(hcy_pkg::CodeMax);
    sec = h6 >> hcy_pkg::FracBits;
    if (sec > 5) sec = 5;
    f = h6 - (sec << hcy_pkg::FracBits);
    xf = sec[0] ? one - f : f;
    case (hcy_pkg::sext_t'(sec))
      hcy_pkg::SecRedYel:  begin a = wr;       b = one - wb; end
      hcy_pkg::SecYelGrn:  begin a = one - wb; b = wg;       end
      hcy_pkg::SecGrnCyan: begin a = wg;       b = one - wr; end
      hcy_pkg::SecCyanBlu: begin a = one - wr; b = wb;       end
      hcy_pkg::SecBluMag:  begin a = wb;       b = one - wg; end
      default:             begin a = one - wg; b = wr;       end
    endcase
    peak = (a * (one - f) + b * f) >> hcy_pkg::FracBits;
    if (y < peak) c = (c * y) / peak;
    else          c = (c * (one - y)) / (one - peak);
    x = (c * xf) >> hcy_pkg::FracBits;
    r = 0; g = 0; bl = 0;
    case (hcy_pkg::sext_t'(sec))
      hcy_pkg::SecRedYel:  begin r = c; g = x;  end
      hcy_pkg::SecYelGrn:  begin r = x; g = c;  end
      hcy_pkg::SecGrnCyan: begin g = c; bl = x; end
      hcy_pkg::SecCyanBlu: begin g = x; bl = c; end
      hcy_pkg::SecBluMag:  begin r = x; bl = c; end
      default:             begin r = c; bl = x; end
    endcase
    sum = (wr * r + wg * g + wb * bl) >> hcy_pkg::FracBits;
    m = longint'(y) - longint'(sum);
    o.r = code_of(longint'(r) + m);
    o.g = code_of(longint'(g) + m);
    o.b = code_of(longint'(bl) + m);
    return o;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_pixel(input hcy_pkg::code_t hue, input hcy_pkg::code_t chroma,
                            input hcy_pkg::code_t luma);
    int gap;
    in_valid  <= 1'b1;
    in_hue    <= hue;
    in_chroma <= chroma;
    in_luma   <= luma;
    do @(posedge clk); while (in_stall);
    pending_rgb.push_back(hcy_to_rgb(hue, chroma, luma));
    gap = in_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_pixel();
    send_pixel(hcy_pkg::code_t'($urandom), hcy_pkg::code_t'($urandom),
               hcy_pkg::code_t'($urandom));
  endtask

  // weights change only with the pipeline empty
  task automatic write_weight(input logic [1:0] idx, input hcy_pkg::weight_t val);
    in_valid <= 1'b0;
    wait (pending_rgb.size() == 0);
    repeat (Drain) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hcy_pkg::RegRedWeight:   wt_red   = val;
      hcy_pkg::RegGreenWeight: wt_green = val;
      hcy_pkg::RegBlueWeight:  wt_blue  = val;
      default: ;
    endcase
  endtask

  task automatic set_weights(input hcy_pkg::weight_t r, input hcy_pkg::weight_t g,
                             input hcy_pkg::weight_t b);
    write_weight(hcy_pkg::RegRedWeight, r);
    write_weight(hcy_pkg::RegGreenWeight, g);
    write_weight(hcy_pkg::RegBlueWeight, b);
  endtask

  task automatic test_directed();
    hcy_pkg::code_t hues[11] = '{8'd0, 8'd1, 8'd42, 8'd43, 8'd85, 8'd127, 8'd128, 8'd170,
                                 8'd212, 8'd254, 8'd255};
    foreach (hues[i]) send_pixel(hues[i], 8'd255, 8'd128);
    send_pixel(8'd30, 8'd0, 8'd0);
    send_pixel(8'd30, 8'd255, 8'd0);
    send_pixel(8'd30, 8'd255, 8'd255);
    send_pixel(8'd200, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd0, 8'd255, 8'd76);    // luma just below the red peak
    send_pixel(8'd170, 8'd255, 8'd29);  // luma just below the blue peak
    send_pixel(8'd85, 8'd170, 8'd200);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
  endtask

  task automatic test_weights();
    write_weight(RegUnused, 16'hFFFF);   // must be ignored
    repeat (20) send_random_pixel();
    set_weights(16'd0, 16'd0, 16'd0);
    repeat (30) send_random_pixel();
    set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (30) send_random_pixel();
    set_weights(16'hFFFF, 16'd0, 16'd1);
    repeat (30) send_random_pixel();
    set_weights(16'd21845, 16'd21845, 16'd21846);
    repeat (30) send_random_pixel();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        set_weights(hcy_pkg::RedWeightRst, hcy_pkg::GreenWeightRst, hcy_pkg::BlueWeightRst);
      end else begin
        set_weights(hcy_pkg::weight_t'($urandom), hcy_pkg::weight_t'($urandom),
                    hcy_pkg::weight_t'($urandom));
      end
      in_gaps  = (phase != 2);
      out_gaps = (phase != 2);
      repeat (60) send_random_pixel();
    end
    in_gaps = 1'b1;
    out_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    in_gaps = 1'b0;
    hold_cycles = 300;
    repeat (80) send_random_pixel();
    in_gaps = 1'b1;
  endtask

  // receiver: long hold when asked, otherwise, while out_gaps is set, stall stretches of random length
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_gaps && ($urandom_range(99) < 30)) stall_left <= 1 + gap_len();
    end
  end

  always @(posedge clk) begin
    rgb_t exp_rgb;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rgb.size() == 0) begin
        $error("result with no pixel outstanding");
        errors++;
      end else begin
        exp_rgb = pending_rgb.pop_front();
        if (out_red !== exp_rgb.r) begin
          $error("red: expected %0d, got %0d", exp_rgb.r, out_red);
          errors++;
        end
        if (out_green !== exp_rgb.g) begin
          $error("green: expected %0d, got %0d", exp_rgb.g, out_green);
          errors++;
        end
        if (out_blue !== exp_rgb.b) begin
          $error("blue: expected %0d, got %0d", exp_rgb.b, out_blue);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_weights();
    test_random();
    test_backpressure();
    in_valid <= 1'b0;
    wait (pending_rgb.size() == 0);
    repeat (Drain) @(posedge clk);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
